// ===== hw/rtl/fcsr_pkg.sv =====
// shared types, constants and response byte builder for the framed command slave responder
package fcsr_pkg;

  localparam int FRAME_BYTES  = 34;
  localparam int BUFFER_BYTES = 128;
  localparam int TXQ_DEPTH    = 2;
  localparam int TXQ_PTR_W    = $clog2(TXQ_DEPTH);
  localparam int TXQ_LVL_W    = $clog2(TXQ_DEPTH + 1);
  localparam int IDX_W        = $clog2(FRAME_BYTES);
  localparam int CNT_W        = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [47:0] PAT_COM = 48'h434F4D2D5354;
  localparam logic [47:0] PAT_RES = 48'h5245532D5354;
  localparam logic [47:0] PAT_END = 48'h4D5347454E44;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic [7:0] CMD_STATUS  = 8'd1;
  localparam logic [7:0] CMD_VERSION = 8'd2;
  localparam logic [7:0] CMD_MEASURE = 8'd3;
  localparam logic [7:0] CMD_DATA    = 8'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_CODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_KIND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_VERSION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_VERSION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT    = 3'd5;

  typedef struct packed {
    logic [7:0]  own_address;
    logic [1:0]  status_code;
    logic [7:0]  sensor_kind;
    logic [15:0] slave_version;
    logic [15:0] sensor_version;
    logic [31:0] measurement_word;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    own_address:      8'd1,
    status_code:      2'd0,
    sensor_kind:      8'd0,
    slave_version:    16'h0112,
    sensor_version:   16'h2034,
    measurement_word: 32'h41240000
  };

  // what a good frame leaves behind for its response
  typedef struct packed {
    logic [7:0] cnt_lo;
    logic [7:0] cnt_hi;
    logic [7:0] cmd;
  } resp_t;

  typedef struct packed {
    logic  valid;
    resp_t data;
  } push_t;

  typedef struct packed {
    logic                 busy;
    logic [TXQ_LVL_W-1:0] level;
  } tx_status_t;

  function automatic logic [7:0] text_byte(input logic [47:0] pat, input logic [2:0] pos);
    logic [2:0] sh;
    sh = 3'd5 - pos;
    return pat[{sh, 3'b000} +: 8];
  endfunction

  // one byte of the response; csum is the sum of bytes 6..25
  function automatic logic [7:0] resp_byte(input logic [IDX_W-1:0] idx, input resp_t r,
                                           input cfg_t c, input logic [7:0] csum);
    logic [7:0] b;
    logic       known;
    known = (r.cmd == CMD_STATUS) || (r.cmd == CMD_VERSION) ||
            (r.cmd == CMD_MEASURE) || (r.cmd == CMD_DATA);
    b = 8'd0;
    case (idx)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: b = text_byte(PAT_RES, idx[2:0]);
      6'd6:  b = r.cnt_lo;
      6'd7:  b = r.cnt_hi;
      6'd8:  b = CH_HASH;
      6'd10: b = c.own_address;
      6'd12: b = known ? CH_STAR : 8'd0;
      6'd13: b = known ? r.cmd : 8'd0;
      6'd14: b = (r.cmd == CMD_STATUS) ? {6'd0, c.status_code} : 8'd0;
      6'd15: begin
        if (r.cmd == CMD_VERSION) b = c.slave_version[7:0];
        else if (r.cmd == CMD_DATA) b = c.measurement_word[7:0];
      end
      6'd16: begin
        if (r.cmd == CMD_STATUS) b = c.sensor_kind;
        else if (r.cmd == CMD_VERSION) b = c.slave_version[15:8];
        else if (r.cmd == CMD_DATA) b = c.measurement_word[15:8];
      end
      6'd17: begin
        if (r.cmd == CMD_VERSION) b = c.sensor_version[7:0];
        else if (r.cmd == CMD_DATA) b = c.measurement_word[23:16];
      end
      6'd18: begin
        if (r.cmd == CMD_VERSION) b = c.sensor_version[15:8];
        else if (r.cmd == CMD_DATA) b = c.measurement_word[31:24];
      end
      6'd26: b = CH_DOLLAR;
      6'd27: b = csum;
      6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33: b = text_byte(PAT_END, 3'(idx - 6'd28));
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/fcsr_rx.sv =====
// receive side: text matching, frame capture and frame check
module fcsr_rx import fcsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output push_t      push
);

  logic [47:0]      win_r, win_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] len_r, len_nxt;
  logic             started_r, started_nxt;
  logic             res_seen_r, res_seen_nxt;
  logic             overlong_r, overlong_nxt;
  // only the frame bytes that matter are kept, plus a running checksum
  logic [7:0]       b6_r, b6_nxt, b7_r, b7_nxt, b9_r, b9_nxt;
  logic [7:0]       b13_r, b13_nxt, b27_r, b27_nxt, sum_r, sum_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [47:0]      win_sh;
  logic             full, m_com, m_res, m_end, frame_ok;

  always_comb begin
    cnt_inc = cnt_r + CNT_W'(1);
    win_sh  = {win_r[39:0], rx_byte};
    full    = cnt_inc >= CNT_W'(6);
    m_com   = full && (win_sh == PAT_COM);
    m_res   = full && (win_sh == PAT_RES);
    m_end   = full && (win_sh == PAT_END);

    win_nxt      = win_sh;
    cnt_nxt      = cnt_inc;
    len_nxt      = len_r;
    started_nxt  = started_r;
    res_seen_nxt = res_seen_r | m_res;
    overlong_nxt = overlong_r;
    b6_nxt  = b6_r;
    b7_nxt  = b7_r;
    b9_nxt  = b9_r;
    b13_nxt = b13_r;
    b27_nxt = b27_r;
    sum_nxt = sum_r;

    if (started_r) begin
      if (len_r < IDX_W'(FRAME_BYTES)) begin
        case (len_r)
          6'd6:    b6_nxt  = rx_byte;
          6'd7:    b7_nxt  = rx_byte;
          6'd9:    b9_nxt  = rx_byte;
          6'd13:   b13_nxt = rx_byte;
          6'd27:   b27_nxt = rx_byte;
          default: ;
        endcase
        if (len_r >= 6'd6 && len_r <= 6'd25) sum_nxt = sum_r + rx_byte;
        len_nxt = len_r + IDX_W'(1);
      end else begin
        overlong_nxt = 1'b1;
      end
    end else if (m_com) begin
      // capture opens with the start text already in place
      started_nxt = 1'b1;
      len_nxt     = 6'd6;
      b6_nxt  = 8'd0;
      b7_nxt  = 8'd0;
      b9_nxt  = 8'd0;
      b13_nxt = 8'd0;
      b27_nxt = 8'd0;
      sum_nxt = 8'd0;
    end

    frame_ok = started_nxt && !res_seen_nxt && !overlong_nxt &&
               (sum_nxt == b27_nxt) && (b9_nxt == cfg.own_address);

    push.valid       = accept && m_end && frame_ok;
    push.data.cnt_lo = b6_nxt;
    push.data.cnt_hi = b7_nxt;
    push.data.cmd    = b13_nxt;

    if (m_end || cnt_inc >= CNT_W'(BUFFER_BYTES)) begin
      win_nxt      = '0;
      cnt_nxt      = '0;
      len_nxt      = '0;
      started_nxt  = 1'b0;
      res_seen_nxt = 1'b0;
      overlong_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      cnt_r      <= '0;
      len_r      <= '0;
      started_r  <= 1'b0;
      res_seen_r <= 1'b0;
      overlong_r <= 1'b0;
      b6_r  <= '0;
      b7_r  <= '0;
      b9_r  <= '0;
      b13_r <= '0;
      b27_r <= '0;
      sum_r <= '0;
    end else if (accept) begin
      win_r      <= win_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      started_r  <= started_nxt;
      res_seen_r <= res_seen_nxt;
      overlong_r <= overlong_nxt;
      b6_r  <= b6_nxt;
      b7_r  <= b7_nxt;
      b9_r  <= b9_nxt;
      b13_r <= b13_nxt;
      b27_r <= b27_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== hw/rtl/fcsr_tx.sv =====
// transmit side: pending response queue, byte serializer and output register
module fcsr_tx import fcsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  input  cfg_t       cfg,
  output logic       q_full,
  output tx_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last
);

  resp_t                q_r [TXQ_DEPTH];
  logic [TXQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [TXQ_LVL_W-1:0] lvl_r, lvl_nxt;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  resp_t            cur_r;
  logic [7:0]       csum_r, csum_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r;
  logic             olast_r;

  logic       pop, load, idx_last;
  logic [7:0] byte_now;

  assign q_full = (lvl_r == TXQ_LVL_W'(TXQ_DEPTH));
  assign pop    = !busy_r && (lvl_r != '0);
  // next byte goes out when the output register is free or draining
  assign load   = busy_r && (!ovalid_r || !out_stall);
  assign idx_last = (idx_r == IDX_W'(FRAME_BYTES - 1));
  assign byte_now = resp_byte(idx_r, cur_r, cfg, csum_r);

  always_comb begin
    lvl_nxt    = lvl_r + TXQ_LVL_W'(push.valid) - TXQ_LVL_W'(pop);
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    csum_nxt   = csum_r;
    ovalid_nxt = ovalid_r && out_stall;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      csum_nxt = '0;
    end else if (load) begin
      ovalid_nxt = 1'b1;
      idx_nxt    = idx_r + IDX_W'(1);
      if (idx_r >= 6'd6 && idx_r <= 6'd25) csum_nxt = csum_r + byte_now;
      if (idx_last) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
      busy_r   <= 1'b0;
      idx_r    <= '0;
      csum_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      lvl_r    <= lvl_nxt;
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      csum_r   <= csum_nxt;
      ovalid_r <= ovalid_nxt;
      if (push.valid) wr_ptr_r <= wr_ptr_r + TXQ_PTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + TXQ_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) q_r[wr_ptr_r] <= push.data;
    if (pop) cur_r <= q_r[rd_ptr_r];
    if (load) begin
      obyte_r <= byte_now;
      olast_r <= idx_last;
    end
  end

  assign status.busy  = busy_r;
  assign status.level = lvl_r;
  assign out_valid    = ovalid_r;
  assign out_tx_byte  = obyte_r;
  assign out_tx_last  = olast_r;

endmodule

// ===== hw/rtl/framed_command_slave_responder.sv =====
// top level: configuration registers, receive frame checker and response transmitter
// Accepts one received byte per clock while in_stall is low. Each byte updates the
// text matcher and the capture in the cycle it is accepted; the byte that completes
// MSGEND on a good frame queues a response. A response leaves as 34 bytes, one per
// cycle when the output is not stalled, with tx_last on the 34th. Up to two responses
// wait in a queue behind the one being sent; in_stall is high only while that queue
// is full, so the input runs at one byte per cycle unless the output side falls
// behind by more than two whole responses.
module framed_command_slave_responder import fcsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_tx_byte,
  output logic                  out_tx_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg_r, cfg_nxt;
  push_t      push;
  tx_status_t tx_status;
  logic       q_full;
  logic       in_accept;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS:    cfg_nxt.own_address      = cfg_wdata[7:0];
        CFG_STATUS_CODE:    cfg_nxt.status_code      = cfg_wdata[1:0];
        CFG_SENSOR_KIND:    cfg_nxt.sensor_kind      = cfg_wdata[7:0];
        CFG_SLAVE_VERSION:  cfg_nxt.slave_version    = cfg_wdata[15:0];
        CFG_SENSOR_VERSION: cfg_nxt.sensor_version   = cfg_wdata[15:0];
        CFG_MEASUREMENT:    cfg_nxt.measurement_word = cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fcsr_rx u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .push    (push)
  );

  fcsr_tx u_tx (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .cfg         (cfg_r),
    .q_full      (q_full),
    .status      (tx_status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_byte (out_tx_byte),
    .out_tx_last (out_tx_last)
  );

  // the response queue never overflows
  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_status.level <= TXQ_LVL_W'(TXQ_DEPTH))
    else $error("response queue level out of range");

  // a queued response is either waiting or being sent in the next cycle
  a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |=> (tx_status.level != '0) || tx_status.busy)
    else $error("queued response lost");

  // the closing byte of every response is the last byte of the end text
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_last |-> out_tx_byte == PAT_END[7:0])
    else $error("last response byte is not the end text");

endmodule

// ===== tb/framed_command_slave_responder_test.sv =====
// testbench for the framed command slave responder: frame stimulus and byte-wise response checks
module framed_command_slave_responder_test;
  import fcsr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 110;

  typedef enum logic [3:0] {
    K_GOOD, K_BAD_SUM, K_BAD_ADDR, K_RES_INSIDE, K_RES_BEFORE, K_NO_COM,
    K_OVERLONG, K_SHORT, K_LATER_COM, K_DISCARD, K_NOISE
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [7:0]  cmd;
    logic [7:0]  fill;
    logic        rand_fill;
    logic        rejected;
  } frame_case_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } tx_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = 8'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_tx_byte;
  logic                  out_tx_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // responder shadow state
  cfg_t       active_cfg = CFG_RESET;
  logic [47:0] rx_window = '0;
  logic [7:0] frame_img [FRAME_BYTES];
  int         frame_fill = 0;
  bit         capturing = 0;
  bit         saw_res = 0;
  bit         over_run = 0;
  int         bytes_since = 0;

  tx_beat_t pending_tx [$];
  int       mismatch_count = 0;
  int       rx_sent = 0;
  int       in_gap_max = 13;
  int       out_wait = 0;
  bit       out_calm = 0;
  int       idle_cycles = 0;

  // rejected = 1 rows expect no response at all
  frame_case_t directed_cases [18] = '{
    '{K_GOOD,       CMD_STATUS,  8'h00, 1'b1, 1'b0},
    '{K_GOOD,       CMD_VERSION, 8'h00, 1'b1, 1'b0},
    '{K_GOOD,       CMD_MEASURE, 8'h00, 1'b1, 1'b0},
    '{K_GOOD,       CMD_DATA,    8'h00, 1'b1, 1'b0},
    '{K_GOOD,       CMD_DATA,    8'h00, 1'b0, 1'b0},
    '{K_GOOD,       CMD_VERSION, 8'hFF, 1'b0, 1'b0},
    '{K_GOOD,       8'h00,       8'h00, 1'b1, 1'b0},
    '{K_GOOD,       8'hFF,       8'h00, 1'b1, 1'b0},
    '{K_BAD_SUM,    CMD_STATUS,  8'h00, 1'b1, 1'b1},
    '{K_BAD_ADDR,   CMD_STATUS,  8'h00, 1'b1, 1'b1},
    '{K_RES_INSIDE, CMD_DATA,    8'h00, 1'b1, 1'b1},
    '{K_RES_BEFORE, CMD_STATUS,  8'h00, 1'b1, 1'b1},
    '{K_NO_COM,     CMD_STATUS,  8'h00, 1'b1, 1'b1},
    '{K_OVERLONG,   CMD_VERSION, 8'h00, 1'b1, 1'b1},
    '{K_SHORT,      CMD_STATUS,  8'h00, 1'b1, 1'b0},
    '{K_LATER_COM,  CMD_DATA,    8'h00, 1'b1, 1'b0},
    '{K_DISCARD,    CMD_STATUS,  8'h00, 1'b1, 1'b1},
    '{K_GOOD,       CMD_STATUS,  8'h00, 1'b1, 1'b0}
  };

  framed_command_slave_responder DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_byte (out_tx_byte),
    .out_tx_last (out_tx_last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] text_at(input logic [47:0] pat, input int pos);
    return pat[8 * (5 - pos) +: 8];
  endfunction

  function automatic void note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  function automatic logic [7:0] span_sum(input logic [7:0] f [FRAME_BYTES]);
    logic [7:0] s;
    s = 8'd0;
    for (int i = 6; i < 26; i++) s += f[i];
    return s;
  endfunction

  function automatic void restart_capture();
    rx_window = '0;
    frame_fill = 0;
    capturing = 0;
    saw_res = 0;
    over_run = 0;
    bytes_since = 0;
  endfunction

  function automatic void queue_response();
    logic [7:0] r [FRAME_BYTES];
    logic [7:0] op;
    op = frame_img[13];
    for (int i = 0; i < FRAME_BYTES; i++) r[i] = 8'd0;
    for (int i = 0; i < 6; i++) begin
      r[i] = text_at(PAT_RES, i);
      r[28 + i] = text_at(PAT_END, i);
    end
    r[6] = frame_img[6];
    r[7] = frame_img[7];
    r[8] = CH_HASH;
    r[10] = active_cfg.own_address;
    if (op >= CMD_STATUS && op <= CMD_DATA) begin
      r[12] = CH_STAR;
      r[13] = op;
    end
    case (op)
      CMD_STATUS: begin
        r[14] = {6'd0, active_cfg.status_code};
        r[16] = active_cfg.sensor_kind;
      end
      CMD_VERSION: begin
        {r[16], r[15]} = active_cfg.slave_version;
        {r[18], r[17]} = active_cfg.sensor_version;
      end
      CMD_DATA: {r[18], r[17], r[16], r[15]} = active_cfg.measurement_word;
      default: ;
    endcase
    r[26] = CH_DOLLAR;
    r[27] = span_sum(r);
    for (int i = 0; i < FRAME_BYTES; i++) pending_tx.push_back('{r[i], i == FRAME_BYTES - 1});
  endfunction

  // advance the shadow by one received byte; record = 0 keeps the response out of the queue
  function automatic void absorb_rx_byte(input logic [7:0] b, input bit record);
    bit full;
    bit good;
    bytes_since++;
    rx_window = {rx_window[39:0], b};
    full = bytes_since >= 6;
    if (full && rx_window == PAT_RES) saw_res = 1;
    if (capturing) begin
      if (frame_fill < FRAME_BYTES) begin
        frame_img[frame_fill] = b;
        frame_fill++;
      end else begin
        over_run = 1;
      end
    end else if (full && rx_window == PAT_COM) begin
      capturing = 1;
      for (int i = 0; i < FRAME_BYTES; i++) frame_img[i] = 8'd0;
      for (int i = 0; i < 6; i++) frame_img[i] = text_at(PAT_COM, i);
      frame_fill = 6;
    end
    if (full && rx_window == PAT_END) begin
      good = capturing && !saw_res && !over_run && span_sum(frame_img) == frame_img[27] &&
             frame_img[9] == active_cfg.own_address;
      restart_capture();
      if (good && record) queue_response();
    end else if (bytes_since >= BUFFER_BYTES) begin
      restart_capture();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit record);
    int gap;
    gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rx_sent++;
    absorb_rx_byte(b, record);
  endtask

  task automatic send_text(input logic [47:0] pat, input bit record);
    for (int i = 0; i < 6; i++) send_byte(text_at(pat, i), record);
  endtask

  task automatic send_frame(input frame_kind_t kind, input logic [7:0] cmd,
                            input logic [7:0] fill, input bit rand_fill, input bit record);
    logic [7:0] f [FRAME_BYTES];
    int n;
    for (int i = 0; i < FRAME_BYTES; i++) f[i] = rand_fill ? 8'($urandom_range(0, 255)) : fill;
    for (int i = 0; i < 6; i++) begin
      f[i] = text_at(PAT_COM, i);
      f[28 + i] = text_at(PAT_END, i);
    end
    f[8] = CH_HASH;
    f[9] = active_cfg.own_address;
    f[12] = CH_STAR;
    f[13] = cmd;
    f[26] = CH_DOLLAR;
    if (kind == K_BAD_ADDR) f[9] = active_cfg.own_address + 8'($urandom_range(1, 255));
    // start texts planted in the payload
    if (kind == K_RES_INSIDE || kind == K_LATER_COM)
      for (int i = 0; i < 6; i++) f[14 + i] = text_at(kind == K_RES_INSIDE ? PAT_RES : PAT_COM, i);
    f[27] = span_sum(f);
    if (kind == K_BAD_SUM) f[27] = f[27] + 8'($urandom_range(1, 255));

    n = $urandom_range(0, 3);
    repeat (n) send_byte(8'($urandom_range(0, 255)), record);
    case (kind)
      K_NOISE: begin
        n = $urandom_range(1, 20);
        repeat (n) send_byte(8'($urandom_range(0, 255)), record);
      end
      K_DISCARD: begin
        // low bytes can never complete a text, so the count runs out mid capture
        send_text(PAT_COM, record);
        repeat (BUFFER_BYTES + 2) send_byte(8'($urandom_range(0, 63)), record);
        send_text(PAT_END, record);
      end
      K_NO_COM: for (int i = 6; i < FRAME_BYTES; i++) send_byte(f[i], record);
      K_OVERLONG: begin
        for (int i = 0; i < 28; i++) send_byte(f[i], record);
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom_range(0, 255)), record);
        for (int i = 28; i < FRAME_BYTES; i++) send_byte(f[i], record);
      end
      K_SHORT: begin
        n = $urandom_range(7, 27);
        for (int i = 0; i < n; i++) send_byte(f[i], record);
        send_text(PAT_END, record);
      end
      K_RES_BEFORE: begin
        send_text(PAT_RES, record);
        for (int i = 0; i < FRAME_BYTES; i++) send_byte(f[i], record);
      end
      default: for (int i = 0; i < FRAME_BYTES; i++) send_byte(f[i], record);
    endcase
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    in_valid <= 1'b0;
    while (pending_tx.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    put_reg(CFG_OWN_ADDRESS, {24'd0, s.own_address});
    put_reg(CFG_STATUS_CODE, {30'd0, s.status_code});
    put_reg(CFG_SENSOR_KIND, {24'd0, s.sensor_kind});
    put_reg(CFG_SLAVE_VERSION, {16'd0, s.slave_version});
    put_reg(CFG_SENSOR_VERSION, {16'd0, s.sensor_version});
    put_reg(CFG_MEASUREMENT, s.measurement_word);
    cfg_we <= 1'b0;
    active_cfg = s;
  endtask

  task automatic random_phase(input cfg_t s);
    int start;
    int r;
    frame_kind_t kind;
    logic [7:0] cmd;
    apply_settings(s);
    start = rx_sent;
    in_gap_max = 13;
    send_frame(K_GOOD, CMD_STATUS, 8'h00, 1'b1, 1'b1);
    while (rx_sent - start < PHASE_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 62) kind = K_GOOD;
      else if (r < 70) kind = K_BAD_SUM;
      else if (r < 75) kind = K_BAD_ADDR;
      else if (r < 79) kind = K_RES_INSIDE;
      else if (r < 81) kind = K_RES_BEFORE;
      else if (r < 84) kind = K_NO_COM;
      else if (r < 89) kind = K_OVERLONG;
      else if (r < 93) kind = K_SHORT;
      else if (r < 96) kind = K_LATER_COM;
      else if (r < 99) kind = K_NOISE;
      else kind = K_DISCARD;
      cmd = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) :
                                          8'($urandom_range(CMD_STATUS, CMD_DATA));
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      send_frame(kind, cmd, 8'h00, 1'b1, 1'b1);
    end
  endtask

  // response checker and receiver stall
  always @(posedge clk) begin
    tx_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_tx.size() == 0) begin
          note_error($sformatf("unexpected response byte %02h last %0b", out_tx_byte, out_tx_last));
        end else begin
          want = pending_tx.pop_front();
          if (out_tx_byte !== want.data)
            note_error($sformatf("tx_byte: expected %02h, got %02h", want.data, out_tx_byte));
          if (out_tx_last !== want.is_last)
            note_error($sformatf("tx_last: expected %0b, got %0b", want.is_last, out_tx_last));
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : $urandom_range(0, 13);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait > 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    cfg_t s;
    for (int i = 0; i < FRAME_BYTES; i++) frame_img[i] = 8'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under the reset settings
    foreach (directed_cases[i])
      send_frame(directed_cases[i].kind, directed_cases[i].cmd, directed_cases[i].fill,
                 directed_cases[i].rand_fill, !directed_cases[i].rejected);

    s = '{own_address: 8'hFF, status_code: 2'd3, sensor_kind: 8'hFF,
          slave_version: 16'hFFFF, sensor_version: 16'hFFFF, measurement_word: 32'hFFFFFFFF};
    random_phase(s);
    s = '0;
    random_phase(s);
    repeat (2) begin
      s.own_address = 8'($urandom_range(0, 255));
      s.status_code = 2'($urandom_range(0, 3));
      s.sensor_kind = 8'($urandom_range(0, 255));
      s.slave_version = 16'($urandom_range(0, 65535));
      s.sensor_version = 16'($urandom_range(0, 65535));
      s.measurement_word = $urandom;
      random_phase(s);
    end

    in_valid <= 1'b0;
    while (pending_tx.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
